// ----- hdl/range_flip_class_xor_table_core_assert.svh -----
// ----------------------------------------------------------------------------
// range_flip_class_xor_table_core assertion macros
// concurrent checks for simulation, empty for synthesis
// ----------------------------------------------------------------------------
`ifndef RANGE_FLIP_CLASS_XOR_TABLE_CORE_ASSERT_SVH
`define RANGE_FLIP_CLASS_XOR_TABLE_CORE_ASSERT_SVH

`ifndef SYNTHESIS

// property must hold at every clock edge outside reset
`define RFXT_ASSERT(label, clk, rst_n, prop) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
		else $error("rfxt assertion failed");

// condition must never be true outside reset
`define RFXT_NEVER(label, clk, rst_n, cond) \
	label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
		else $error("rfxt forbidden condition seen");

`else

`define RFXT_ASSERT(label, clk, rst_n, prop)
`define RFXT_NEVER(label, clk, rst_n, cond)

`endif

`endif

// ----- hdl/rfxt_pkg.sv -----
// ----------------------------------------------------------------------------
// rfxt_pkg
// shared constants and types for the range flip class xor table
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package rfxt_pkg;

	localparam int TABLE_DEPTH = 1024;
	localparam int VALUE_BITS  = 30;
	localparam int ADDR_BITS   = $clog2(TABLE_DEPTH);
	localparam int COUNT_BITS  = ADDR_BITS + 1;
	localparam int INDEX_BITS  = 11;

	// operation codes
	typedef enum logic [1:0] {
		FUNC_CLEAR = 2'd0,
		FUNC_LOAD  = 2'd1,
		FUNC_FLIP  = 2'd2,
		FUNC_QUERY = 2'd3
	} func_t;

	// request transaction
	typedef struct packed {
		func_t                   func;
		logic [INDEX_BITS-1:0]   left_index;
		logic [INDEX_BITS-1:0]   right_index;
		logic [VALUE_BITS-1:0]   element_value;
		logic                    element_bit;
		logic                    query_class;
	} req_item_t;

	// response transaction
	typedef struct packed {
		logic [VALUE_BITS-1:0] xor_result;
		logic                  bad_request;
	} rsp_item_t;

	// prefix memory access
	typedef struct packed {
		logic                  we;
		logic                  re;
		logic [ADDR_BITS-1:0]  addr;
		logic [VALUE_BITS-1:0] wdata;
	} mem_req_t;

	// sequencer to totals/response path
	typedef struct packed {
		logic                  clear;
		logic                  load;
		logic                  load_cls;
		logic [VALUE_BITS-1:0] load_value;
		logic                  flip_apply;
		logic [VALUE_BITS-1:0] span;
		logic                  rsp_fire;
		logic                  rsp_bad;
		logic                  rsp_cls;
	} upd_t;

endpackage

`default_nettype wire

// ----- hdl/rfxt_prefix_ram.sv -----
// ----------------------------------------------------------------------------
// rfxt_prefix_ram
// single-port synchronous prefix-xor store, registered read
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module rfxt_prefix_ram
	import rfxt_pkg::*;
(
	input  wire logic                  clk,
	input  wire mem_req_t              mem,
	output logic      [VALUE_BITS-1:0] rdata
);

	logic [VALUE_BITS-1:0] store_q [TABLE_DEPTH];
	logic [VALUE_BITS-1:0] rdata_q;

	// write port
	always_ff @(posedge clk) begin
		if (mem.we) begin
			store_q[mem.addr] <= mem.wdata;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		if (mem.re) begin
			rdata_q <= store_q[mem.addr];
		end
	end

	assign rdata = rdata_q;

endmodule

`default_nettype wire

// ----- hdl/rfxt_ctrl.sv -----
// ----------------------------------------------------------------------------
// rfxt_ctrl
// request sequencer: load append, flip range reads, request checks
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "range_flip_class_xor_table_core_assert.svh"

module rfxt_ctrl
	import rfxt_pkg::*;
(
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  req_valid,
	output logic                       req_ready,
	input  wire req_item_t             req,
	input  wire logic                  rsp_room,
	input  wire logic [VALUE_BITS-1:0] rdata,
	output mem_req_t                   mem,
	output upd_t                       upd
);

	typedef enum logic [2:0] {
		ST_IDLE  = 3'b001,
		ST_RD_HI = 3'b010,
		ST_RD_LO = 3'b100
	} seq_state_t;

	seq_state_t            state_q;
	logic [COUNT_BITS-1:0] count_q;
	logic [VALUE_BITS-1:0] last_prefix_q;
	logic [ADDR_BITS-1:0]  lo_addr_q;
	logic                  lo_first_q;
	logic [VALUE_BITS-1:0] span_s1;

	logic                  accept;
	logic                  load_full;
	logic                  flip_bad;
	logic                  is_load;
	logic                  is_flip;
	logic [INDEX_BITS-1:0] hi_minus1;
	logic [INDEX_BITS-1:0] lo_minus2;
	logic [VALUE_BITS-1:0] lo_prefix;

	// handshake: free in idle or while the last flip read returns, and only when the response slot has room
	assign req_ready = ((state_q == ST_IDLE) || (state_q == ST_RD_LO)) && rsp_room;
	assign accept    = req_valid && req_ready;

	// request checks
	assign load_full = (count_q == COUNT_BITS'(TABLE_DEPTH));
	assign flip_bad  = (req.left_index == '0)
	                 || (req.right_index < req.left_index)
	                 || (req.right_index > INDEX_BITS'(count_q));
	assign is_load   = accept && (req.func == FUNC_LOAD) && !load_full;
	assign is_flip   = accept && (req.func == FUNC_FLIP) && !flip_bad;

	assign hi_minus1 = req.right_index - INDEX_BITS'(1);
	assign lo_minus2 = req.left_index - INDEX_BITS'(2);

	// memory port: load write, hi read on accept, lo read in the cycle after
	always_comb begin
		mem.we    = is_load;
		mem.re    = is_flip || ((state_q == ST_RD_HI) && !lo_first_q);
		mem.wdata = last_prefix_q ^ req.element_value;
		if (is_load) begin
			mem.addr = count_q[ADDR_BITS-1:0];
		end else if (state_q == ST_RD_HI) begin
			mem.addr = lo_addr_q;
		end else begin
			mem.addr = hi_minus1[ADDR_BITS-1:0];
		end
	end

	// empty prefix reads as zero
	assign lo_prefix = lo_first_q ? '0 : rdata;

	// update bundle for the totals and response path
	always_comb begin
		upd.clear      = accept && (req.func == FUNC_CLEAR);
		upd.load       = is_load;
		upd.load_cls   = req.element_bit;
		upd.load_value = req.element_value;
		upd.flip_apply = (state_q == ST_RD_LO);
		upd.span       = span_s1 ^ lo_prefix;
		upd.rsp_fire   = accept && ((req.func == FUNC_QUERY)
		               || ((req.func == FUNC_LOAD) && load_full)
		               || ((req.func == FUNC_FLIP) && flip_bad));
		upd.rsp_bad    = (req.func != FUNC_QUERY);
		upd.rsp_cls    = req.query_class;
	end

	// sequencer state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			case (state_q)
				ST_IDLE:  state_q <= is_flip ? ST_RD_HI : ST_IDLE;
				ST_RD_HI: state_q <= ST_RD_LO;
				ST_RD_LO: state_q <= is_flip ? ST_RD_HI : ST_IDLE;
				default:  state_q <= ST_IDLE;
			endcase
		end
	end

	// table fill count and prefix of the last entry
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q       <= '0;
			last_prefix_q <= '0;
		end else if (upd.clear) begin
			count_q       <= '0;
			last_prefix_q <= '0;
		end else if (is_load) begin
			count_q       <= count_q + COUNT_BITS'(1);
			last_prefix_q <= mem.wdata;
		end
	end

	// flip range bookkeeping
	always_ff @(posedge clk) begin
		if (is_flip) begin
			lo_addr_q  <= lo_minus2[ADDR_BITS-1:0];
			lo_first_q <= (req.left_index == INDEX_BITS'(1));
		end
		if (state_q == ST_RD_HI) begin
			span_s1 <= rdata;
		end
	end

	// checks
	`RFXT_ASSERT(a_flip_enters_read, clk, arst_n, is_flip |=> (state_q == ST_RD_HI))
	`RFXT_ASSERT(a_busy_no_accept, clk, arst_n, (state_q == ST_RD_HI) |-> !req_ready)
	`RFXT_NEVER(a_port_conflict, clk, arst_n, mem.we && mem.re)
	`RFXT_ASSERT(a_count_bound, clk, arst_n, count_q <= COUNT_BITS'(TABLE_DEPTH))

endmodule

`default_nettype wire

// ----- hdl/range_flip_class_xor_table_core.sv -----
// ----------------------------------------------------------------------------
// range_flip_class_xor_table_core
// table of values with class bits, class xor totals and range flips
// ----------------------------------------------------------------------------
// Requests enter on req_valid/req_ready as req_item_t, responses leave on
// rsp_valid/rsp_ready as rsp_item_t.
// Clear, load and query complete on acceptance; a flip makes two reads of the
// single-port prefix memory (right end, then left end).
// Query responses and bad-request responses appear registered, in the cycle
// after the request transaction; good clears, loads and flips give none.
// Sustained rate: one transaction per cycle for clear/load/query while the
// response slot has room; a flip blocks the next request until its left-end read.
// A pending response blocks a new request only while rsp_ready is low;
// with rsp_ready high the response slot frees in the same cycle.
// Reset empties the table and zeroes both totals; no clearing pass is run,
// since entries beyond the fill count are never read.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module range_flip_class_xor_table_core
	import rfxt_pkg::*;
(
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      req_valid,
	output logic           req_ready,
	input  wire req_item_t req,
	output logic           rsp_valid,
	input  wire logic      rsp_ready,
	output rsp_item_t      rsp
);

	mem_req_t              mem;
	upd_t                  upd;
	logic [VALUE_BITS-1:0] rdata;
	logic                  rsp_room;

	logic [VALUE_BITS-1:0] tot0_q;
	logic [VALUE_BITS-1:0] tot1_q;
	logic [VALUE_BITS-1:0] tot0_cur;
	logic [VALUE_BITS-1:0] tot1_cur;
	logic                  rsp_valid_q;
	rsp_item_t             rsp_q;

	rfxt_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.req       (req),
		.rsp_room  (rsp_room),
		.rdata     (rdata),
		.mem       (mem),
		.upd       (upd)
	);

	rfxt_prefix_ram u_ram (
		.clk   (clk),
		.mem   (mem),
		.rdata (rdata)
	);

	// totals with the finishing flip forwarded
	assign tot0_cur = upd.flip_apply ? (tot0_q ^ upd.span) : tot0_q;
	assign tot1_cur = upd.flip_apply ? (tot1_q ^ upd.span) : tot1_q;

	// class totals
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tot0_q <= '0;
			tot1_q <= '0;
		end else if (upd.clear) begin
			tot0_q <= '0;
			tot1_q <= '0;
		end else begin
			tot0_q <= (upd.load && !upd.load_cls) ? (tot0_cur ^ upd.load_value) : tot0_cur;
			tot1_q <= (upd.load && upd.load_cls) ? (tot1_cur ^ upd.load_value) : tot1_cur;
		end
	end

	// response register
	assign rsp_room = !rsp_valid_q || rsp_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (upd.rsp_fire) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp_ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (upd.rsp_fire) begin
			rsp_q.bad_request <= upd.rsp_bad;
			if (upd.rsp_bad) begin
				rsp_q.xor_result <= '0;
			end else begin
				rsp_q.xor_result <= upd.rsp_cls ? tot1_cur : tot0_cur;
			end
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

endmodule

`default_nettype wire
